// ===== sv/blet_pkg.sv =====
`default_nettype none
package blet_pkg;

  localparam int unsigned WindowDepth = 8;
  localparam int unsigned SlotW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;

  localparam logic [2:0] RegMidRate    = 3'd0;
  localparam logic [2:0] RegPeakRise   = 3'd1;
  localparam logic [2:0] RegPeakFall   = 3'd2;
  localparam logic [2:0] RegPeakHold   = 3'd3;
  localparam logic [2:0] RegPeakFloor  = 3'd4;
  localparam logic [2:0] RegTroughFall = 3'd5;
  localparam logic [2:0] RegTroughRise = 3'd6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture input beat, step midpoint
    logic dev;       // finish midpoint, restart window scan
    logic scan;      // fold one window entry into the level
    logic peak_mul;  // peak blend products
    logic peak_upd;  // peak / hold / floor, trough blend products
    logic trough;    // trough blend
    logic div_init;  // start both divisions
    logic div_step;  // one quotient bit each
    logic publish;   // move quotients to the output register
  } blet_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
  } blet_sts_t;

  // floor((old*(65536-r) + nw*r) / 65536), one 32x17 product each side
  function automatic logic [31:0] blend_fn(input logic [48:0] pa, input logic [48:0] pb);
    logic [49:0] s;
    s = {1'b0, pa} + {1'b0, pb};
    return s[47:16];
  endfunction

endpackage
`default_nettype wire

// ===== sv/blet_ctrl.sv =====
`default_nettype none
module blet_ctrl import blet_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire blet_sts_t sts_i,
  output blet_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MID, S_DEV, S_SCAN, S_PMUL, S_PUPD, S_TROUGH, S_DINIT, S_DIV, S_PUB
  } state_e;

  state_e state_q;
  logic   ovalid_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.dev      = (state_q == S_DEV);
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.peak_mul = (state_q == S_PMUL);
    cmd_o.peak_upd = (state_q == S_PUPD);
    cmd_o.trough   = (state_q == S_TROUGH);
    cmd_o.div_init = (state_q == S_DINIT);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.publish  = (state_q == S_PUB) && !(ovalid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (state_q == S_PUB && !(ovalid_q && out_stall_i)) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_MID;
        S_MID:    state_q <= S_DEV;
        S_DEV:    state_q <= S_SCAN;
        S_SCAN:   if (sts_i.scan_last) state_q <= S_PMUL;
        S_PMUL:   state_q <= S_PUPD;
        S_PUPD:   state_q <= S_TROUGH;
        S_TROUGH: state_q <= S_DINIT;
        S_DINIT:  state_q <= S_DIV;
        S_DIV:    if (sts_i.div_last) state_q <= S_PUB;
        S_PUB: begin
          if (!(ovalid_q && out_stall_i)) begin
            state_q  <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accepting while busy");
  a_pub_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> (ovalid_q && state_q == S_IDLE)) else $error("publish lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> ovalid_q) else $error("result dropped");

endmodule
`default_nettype wire

// ===== sv/blet_dp.sv =====
`default_nettype none
module blet_dp import blet_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] magnitude_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [15:0] midpoint_rate_i,
  input  wire logic [15:0] peak_rise_rate_i,
  input  wire logic [15:0] peak_fall_rate_i,
  input  wire logic [15:0] peak_hold_ms_i,
  input  wire logic [15:0] peak_floor_i,
  input  wire logic [15:0] trough_fall_rate_i,
  input  wire logic [15:0] trough_rise_rate_i,
  input  wire blet_cmd_t   cmd_i,
  output blet_sts_t        sts_o,
  output logic [7:0]       intensity_o,
  output logic [7:0]       beat_intensity_o
);

  logic [31:0] mid_q, peak_q, trough_q, lpt_q, mag_q, now_q, dev_q;
  logic [15:0] win_q [WindowDepth];
  logic [SlotW-1:0] slot_q, scan_q;
  logic [15:0] lvl_q;
  logic [48:0] pa_q, pb_q;
  logic        rise_q, decay_q;
  logic [7:0]  inten_q, beat_q;

  // divider state: numerators * 255 shifted out one bit a step
  logic [40:0] n1_q, n2_q;
  logic [32:0] r1_q, r2_q;
  logic [31:0] d1_q, d2_q;
  logic [7:0]  q1_q, q2_q;
  logic        z1_q, z2_q;
  logic [5:0]  dcnt_q;

  logic [16:0] rmid;
  logic [31:0] mag32, dev_d, lvl32;
  logic [33:0] r1_sh, r2_sh;
  logic [32:0] den2, above2;

  assign mag32 = {magnitude_i, 16'd0};
  assign rmid  = {1'b0, midpoint_rate_i};
  assign lvl32 = {lvl_q, 16'd0};
  assign dev_d = (mag_q > mid_q) ? mag_q - mid_q : mid_q - mag_q;
  assign den2   = {1'b0, peak_q} - {1'b0, trough_q};
  assign above2 = {1'b0, lvl32} - {1'b0, trough_q};
  assign r1_sh  = {r1_q, n1_q[40]};
  assign r2_sh  = {r2_q, n2_q[40]};

  assign sts_o.scan_last = (scan_q == SlotW'(WindowDepth - 1));
  assign sts_o.div_last  = (dcnt_q == 6'd40);
  assign intensity_o      = inten_q;
  assign beat_intensity_o = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0; peak_q <= '0; trough_q <= '0; lpt_q <= '0; slot_q <= '0;
      for (int i = 0; i < WindowDepth; i++) win_q[i] <= '0;
    end else begin
      if (cmd_i.load) begin
        mag_q <= mag32;
        now_q <= now_ms_i;
        pa_q  <= 49'(mid_q) * 49'(17'h10000 - rmid);
        pb_q  <= 49'(mag32) * 49'(rmid);
      end
      if (cmd_i.dev) begin
        // midpoint finishes here; deviation uses the new midpoint next
        mid_q <= (mid_q == '0) ? mag_q : blend_fn(pa_q, pb_q);
      end
      if (cmd_i.scan && scan_q == '0) begin
        // first scan cycle: compute deviation and write slot
        dev_q <= dev_d;
        win_q[slot_q] <= dev_d[31:16];
        slot_q <= (slot_q == SlotW'(WindowDepth - 1)) ? '0 : slot_q + 1'b1;
      end
      if (cmd_i.peak_mul) begin
        rise_q  <= dev_q > peak_q;
        decay_q <= (now_q - lpt_q) > {16'd0, peak_hold_ms_i};
        if (dev_q > peak_q) begin
          pa_q <= 49'(peak_q) * 49'(17'h10000 - {1'b0, peak_rise_rate_i});
          pb_q <= 49'(dev_q) * 49'({1'b0, peak_rise_rate_i});
        end else begin
          pa_q <= 49'(peak_q) * 49'(17'h10000 - {1'b0, peak_fall_rate_i});
          pb_q <= 49'(dev_q) * 49'({1'b0, peak_fall_rate_i});
        end
      end
      if (cmd_i.peak_upd) begin
        if (rise_q) lpt_q <= now_q;
        if ((rise_q || decay_q) && blend_fn(pa_q, pb_q) >= {peak_floor_i, 16'd0})
          peak_q <= blend_fn(pa_q, pb_q);
        else if (rise_q || decay_q || peak_q < {peak_floor_i, 16'd0})
          peak_q <= {peak_floor_i, 16'd0};
        if (lvl32 < trough_q) begin
          pa_q <= 49'(trough_q) * 49'(17'h10000 - {1'b0, trough_fall_rate_i});
          pb_q <= 49'(lvl32) * 49'({1'b0, trough_fall_rate_i});
        end else begin
          pa_q <= 49'(trough_q) * 49'(17'h10000 - {1'b0, trough_rise_rate_i});
          pb_q <= 49'(lvl32) * 49'({1'b0, trough_rise_rate_i});
        end
      end
      if (cmd_i.trough) trough_q <= blend_fn(pa_q, pb_q);
    end
  end

  // window maximum over cycles; entry just written to slot 0 is seen via dev_d on that slot's cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      lvl_q  <= '0;
    end else if (cmd_i.dev) begin
      scan_q <= '0;
      lvl_q  <= '0;
    end else if (cmd_i.scan) begin
      if (scan_q == slot_q && scan_q == '0) begin
        if (dev_d[31:16] > lvl_q) lvl_q <= dev_d[31:16];
      end else if (scan_q != '0 || slot_q != '0) begin
        if (win_q[scan_q] > lvl_q) lvl_q <= win_q[scan_q];
      end
      scan_q <= sts_o.scan_last ? '0 : scan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      d1_q <= peak_q;
      z1_q <= (peak_q == '0);
      n1_q <= 41'((lvl32 < peak_q) ? lvl32 : peak_q) * 41'd255;
      d2_q <= den2[31:0];
      z2_q <= den2[32] || den2 == '0 || above2[32] || above2 == '0;
      n2_q <= 41'((above2 < den2) ? above2[31:0] : den2[31:0]) * 41'd255;
      r1_q <= '0; r2_q <= '0; q1_q <= '0; q2_q <= '0; dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      n1_q <= {n1_q[39:0], 1'b0};
      n2_q <= {n2_q[39:0], 1'b0};
      if (r1_sh >= {2'b0, d1_q}) begin
        r1_q <= 33'(r1_sh - {2'b0, d1_q}); q1_q <= {q1_q[6:0], 1'b1};
      end else begin
        r1_q <= r1_sh[32:0]; q1_q <= {q1_q[6:0], 1'b0};
      end
      if (r2_sh >= {2'b0, d2_q}) begin
        r2_q <= 33'(r2_sh - {2'b0, d2_q}); q2_q <= {q2_q[6:0], 1'b1};
      end else begin
        r2_q <= r2_sh[32:0]; q2_q <= {q2_q[6:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.publish) begin
      inten_q <= z1_q ? 8'd0 : q1_q;
      beat_q  <= z2_q ? 8'd0 : q2_q;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bass_level_envelope_tracker.sv =====
`default_nettype none
// Each input beat runs through load, midpoint, deviation, window scan, peak and trough blends,
// the 41-step restoring divider and publish; the next beat waits until the last is published.
// Input is stalled while an item is in work; a finished result waits in the output register.
// Reset (rst_ni low, asynchronous) clears levels, hold time and the window, and sets config registers to defaults.
module bass_level_envelope_tracker import blet_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] magnitude_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       intensity_o,
  output logic [7:0]       beat_intensity_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] mid_rate_q, rise_q, fall_q, hold_q, floor_q, tfall_q, trise_q;
  blet_cmd_t cmd;
  blet_sts_t sts;

  // configuration registers; unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_rate_q <= 16'd655;  rise_q  <= 16'd32768; fall_q  <= 16'd655;
      hold_q     <= 16'd1000; floor_q <= 16'd100;   tfall_q <= 16'd6554;
      trise_q    <= 16'd655;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMidRate:    mid_rate_q <= cfg_data_i;
        RegPeakRise:   rise_q     <= cfg_data_i;
        RegPeakFall:   fall_q     <= cfg_data_i;
        RegPeakHold:   hold_q     <= cfg_data_i;
        RegPeakFloor:  floor_q    <= cfg_data_i;
        RegTroughFall: tfall_q    <= cfg_data_i;
        RegTroughRise: trise_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  blet_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  blet_dp u_dp (
    .clk_i, .rst_ni, .magnitude_i, .now_ms_i,
    .midpoint_rate_i(mid_rate_q), .peak_rise_rate_i(rise_q), .peak_fall_rate_i(fall_q),
    .peak_hold_ms_i(hold_q), .peak_floor_i(floor_q), .trough_fall_rate_i(tfall_q),
    .trough_rise_rate_i(trise_q), .cmd_i(cmd), .sts_o(sts),
    .intensity_o, .beat_intensity_o
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import blet_pkg::*;

  // Register index past the end of the map; the block must ignore it
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned SettleCycles = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] magnitude_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  intensity_o;
  logic [7:0]  beat_intensity_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  bass_level_envelope_tracker dut (.*);

  typedef struct {
    logic [15:0] mag;
    logic [31:0] now;
  } sample_t;

  typedef struct {
    logic [7:0] inten;
    logic [7:0] beat;
  } levels_t;

  sample_t pending_beats[$];
  sample_t in_flight[$];
  levels_t level_expect_q[$];

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_taken = 0;
  int unsigned results_seen = 0;
  bit          calm = 1'b0;

  // Shadow copy of the block's registers and envelope state
  logic [15:0] mid_rate, rise_rate, fall_rate, hold_ms, floor_int, tfall_rate, trise_rate;
  logic [31:0] mid_q, peak_q, trough_q, peak_stamp;
  logic [15:0] dev_ring [WindowDepth];
  int unsigned ring_pos;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [31:0] mix(logic [31:0] old, logic [31:0] nw, logic [15:0] rate);
    logic [63:0] acc;
    acc = 64'(old) * (64'd65536 - 64'(rate)) + 64'(nw) * 64'(rate);
    return acc[47:16];
  endfunction

  task automatic reset_shadow();
    mid_rate = 16'd655;   rise_rate = 16'd32768; fall_rate = 16'd655;
    hold_ms = 16'd1000;   floor_int = 16'd100;
    tfall_rate = 16'd6554; trise_rate = 16'd655;
    mid_q = '0; peak_q = '0; trough_q = '0; peak_stamp = '0;
    foreach (dev_ring[i]) dev_ring[i] = '0;
    ring_pos = 0;
  endtask

  // Advance the envelope by one sample and return the two intensities
  function automatic levels_t envelope_step(sample_t s);
    logic [31:0] m, dev, lvl, floor_q;
    logic [15:0] top;
    logic [63:0] num;
    longint      den, above;
    levels_t     r;
    m = {s.mag, 16'h0};
    mid_q = (mid_q == 0) ? m : mix(mid_q, m, mid_rate);
    dev = (m > mid_q) ? m - mid_q : mid_q - m;
    dev_ring[ring_pos] = dev[31:16];
    ring_pos = (ring_pos + 1) % WindowDepth;
    top = '0;
    foreach (dev_ring[i]) if (dev_ring[i] > top) top = dev_ring[i];
    lvl = {top, 16'h0};
    if (dev > peak_q) begin
      peak_stamp = s.now;
      peak_q = mix(peak_q, dev, rise_rate);
    end else if (32'(s.now - peak_stamp) > 32'(hold_ms)) begin
      peak_q = mix(peak_q, dev, fall_rate);
    end
    floor_q = {floor_int, 16'h0};
    if (peak_q < floor_q) peak_q = floor_q;
    trough_q = mix(trough_q, lvl, (lvl < trough_q) ? tfall_rate : trise_rate);
    r.inten = '0;
    if (peak_q != 0) begin
      num = (lvl < peak_q) ? 64'(lvl) : 64'(peak_q);
      r.inten = 8'((num * 255) / 64'(peak_q));
    end
    r.beat = '0;
    den = longint'(peak_q) - longint'(trough_q);
    above = longint'(lvl) - longint'(trough_q);
    if (den > 0 && above > 0) begin
      num = 64'((above < den) ? above : den);
      r.beat = 8'((num * 255) / 64'(den));
    end
    return r;
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Write one register at an idle moment and mirror it in the shadow copy
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegMidRate:    mid_rate = val;
      RegPeakRise:   rise_rate = val;
      RegPeakFall:   fall_rate = val;
      RegPeakHold:   hold_ms = val;
      RegPeakFloor:  floor_int = val;
      RegTroughFall: tfall_rate = val;
      RegTroughRise: trise_rate = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2, logic [15:0] v3,
                           logic [15:0] v4, logic [15:0] v5, logic [15:0] v6);
    write_reg(RegMidRate, v0);   write_reg(RegPeakRise, v1);  write_reg(RegPeakFall, v2);
    write_reg(RegPeakHold, v3);  write_reg(RegPeakFloor, v4);
    write_reg(RegTroughFall, v5); write_reg(RegTroughRise, v6);
  endtask

  // Hold until every queued beat is in and every result is out, then let the block settle
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid_i || level_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  logic [31:0] clock_ms = 32'd0;

  task automatic push(logic [15:0] mag, logic [31:0] now);
    sample_t s;
    s.mag = mag;
    s.now = now;
    pending_beats.push_back(s);
  endtask

  // Mostly a running tick with bass-like pulses; some full-range noise and time jumps
  task automatic push_random(int unsigned n);
    logic [15:0] mag;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) mag = 16'($urandom_range(0, 400));
      else if (pick < 75) mag = 16'($urandom_range(2000, 20000));
      else if (pick < 92) mag = 16'($urandom);
      else mag = pick[0] ? 16'hFFFF : 16'h0000;
      clock_ms += $urandom_range(0, 40);
      if ($urandom_range(0, 39) == 0) clock_ms += $urandom_range(500, 70000);
      if ($urandom_range(0, 99) == 0) clock_ms = $urandom;
      push(mag, clock_ms);
    end
  endtask

  // Driver: present beats at the falling edge, hold while not yet taken
  int unsigned src_gap = 0;
  always @(negedge clk_i) begin
    sample_t s;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && beats_taken != beats_sent) begin
      in_valid_i <= 1'b1;
    end else if (src_gap != 0) begin
      src_gap--;
      in_valid_i <= 1'b0;
    end else if (pending_beats.size() != 0) begin
      s = pending_beats.pop_front();
      magnitude_i <= s.mag;
      now_ms_i <= s.now;
      in_flight.push_back(s);
      beats_sent++;
      in_valid_i <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 15);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver back-pressure in bursts
  int unsigned sink_gap = 0;
  always @(negedge clk_i) begin
    if (sink_gap != 0) begin
      sink_gap--;
      out_stall_i <= 1'b1;
    end else if (!calm && rst_ni && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Predict on every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      level_expect_q.push_back(envelope_step(in_flight.pop_front()));
      beats_taken++;
    end
  end

  // Monitor: compare each accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    levels_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (level_expect_q.size() == 0) begin
        report("unexpected result", intensity_o, 8'd0);
      end else begin
        want = level_expect_q.pop_front();
        if (intensity_o !== want.inten) report("intensity", intensity_o, want.inten);
        if (beat_intensity_o !== want.beat) report("beat_intensity", beat_intensity_o, want.beat);
      end
    end
  end

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero floor so a zero peak is reachable, plus an ignored register write
    write_reg(RegPeakFloor, 16'd0);
    write_reg(RegUnused, 16'hFFFF);
    push(16'd0, 32'd0);          // midpoint stays empty, zero peak
    push(16'd0, 32'd5);
    push(16'hFFFF, 32'd10);      // first load of midpoint
    push(16'hFFFF, 32'd11);
    push(16'd1, 32'd12);
    push(16'd0, 32'd20);
    push(16'd30000, 32'd30);
    push(16'd30000, 32'd1030);   // hold boundary
    push(16'd30000, 32'd1031);
    push(16'd100, 32'd3000);
    push(16'd100, 32'd4000);
    push(16'd100, 32'd4001);
    push(16'hFFFF, 32'hFFFF_FF00);
    push(16'd0, 32'hFFFF_FFFF);
    push(16'd50, 32'h0000_0100); // tick wrapped past the hold
    push(16'd50, 32'h0000_0500);
    push(16'h8000, 32'h5555_5555);
    push(16'h7FFF, 32'hAAAA_AAAA);
    push(16'd0, 32'hAAAA_AAAB);
    push(16'd0, 32'hAAAB_0000);
    drain();

    write_all(16'd655, 16'd32768, 16'd655, 16'd1000, 16'd100, 16'd6554, 16'd655);
    push_random(400);
    drain();

    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_random(250);
    drain();

    write_all(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    push_random(250);
    drain();

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 2000)), 16'($urandom), 16'($urandom));
    push_random(300);
    drain();

    // Last stretch at full rate on both sides
    calm = 1'b1;
    write_all(16'($urandom_range(100, 5000)), 16'($urandom), 16'($urandom_range(0, 4000)),
              16'($urandom_range(0, 500)), 16'($urandom_range(0, 300)),
              16'($urandom), 16'($urandom_range(0, 4000)));
    push_random(250);
    drain();

    $display("Covered %0d input beats and %0d results over six register settings,",
             beats_taken, results_seen);
    $display("including zero and full-scale rates, hold and floor, with random back-pressure.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/blet_pkg.sv
sv/blet_ctrl.sv
sv/blet_dp.sv
sv/bass_level_envelope_tracker.sv
test/testbench.sv
